// ----- hdl/lctc_pkg.sv -----
// Shared types, constants and a helper function for the LCD clock timing calculator.
package lctc_pkg;

  localparam int unsigned REF_HZ        = 12000000;
  localparam int unsigned FAST_HZ       = 37500000;
  localparam int unsigned FASTER_HZ     = 60000000;
  localparam int unsigned DIV_MAX       = 1023;
  localparam int unsigned BLANK_MAX     = 255;

  // ceil(2^50 / 500000): exact floor(f / 500000) for any f below 2^31
  localparam int unsigned RECIP_SHIFT   = 50;
  localparam logic [31:0] PIX_RECIP     = 32'd2251799814;

  localparam int unsigned NUM_W         = 32;
  localparam int unsigned DSR_W         = 7;
  localparam int unsigned HZ_W          = 31;
  localparam int unsigned SLOW_W        = 24;
  localparam int unsigned PROD_W        = HZ_W + 32;
  localparam int unsigned Q500_W        = PROD_W - RECIP_SHIFT;

  localparam int unsigned DIV_STEPS     = 8;
  localparam int unsigned DIV_STAGES    = NUM_W / DIV_STEPS;

  typedef struct packed {
    logic [19:0] pll_control;
    logic [7:0]  slow_control;
    logic [1:0]  divider_control;
    logic [31:0] lcd_word1_in;
    logic [31:0] lcd_word3_in;
    logic [31:0] lcd_word4_in;
  } lctc_in_t;

  typedef struct packed {
    logic [31:0] lcd_word1_out;
    logic [31:0] lcd_word3_out;
    logic [31:0] lcd_word4_out;
    logic [30:0] bus_clock_hz;
  } lctc_out_t;

  // fields that ride alongside the divider
  typedef struct packed {
    logic              slow_mode;
    logic [SLOW_W-1:0] slow_hz;
    logic [1:0]        sdiv;
    logic              halve;
    logic [6:0]        w1_keep;
    logic [10:0]       w3_keep;
    logic [23:0]       w4_keep;
  } lctc_ctx_t;

  typedef struct packed {
    logic              valid;
    logic [DSR_W-1:0]  rem;
    logic [NUM_W-1:0]  nq;
    logic [DSR_W-1:0]  dsr;
    lctc_ctx_t         ctx;
  } lctc_div_t;

  // core clock in slow mode; a zero divider leaves the reference as is
  function automatic logic [SLOW_W-1:0] slow_clock(input logic [2:0] sdv);
    logic [SLOW_W-1:0] hz;
    case (sdv)
      3'd1:    hz = SLOW_W'(REF_HZ / 2);
      3'd2:    hz = SLOW_W'(REF_HZ / 4);
      3'd3:    hz = SLOW_W'(REF_HZ / 6);
      3'd4:    hz = SLOW_W'(REF_HZ / 8);
      3'd5:    hz = SLOW_W'(REF_HZ / 10);
      3'd6:    hz = SLOW_W'(REF_HZ / 12);
      3'd7:    hz = SLOW_W'(REF_HZ / 14);
      default: hz = SLOW_W'(REF_HZ);
    endcase
    return hz;
  endfunction

endpackage

// ----- hdl/lctc_front.sv -----
// Input stage: field decode, PLL numerator product and slow-mode clock lookup.
module lctc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  lctc_pkg::lctc_in_t in_data,
  output lctc_pkg::lctc_div_t div_out
);
  import lctc_pkg::*;

  lctc_div_t   stage_nxt;
  logic        valid_r;
  lctc_div_t   data_r;
  logic [8:0]  mul;
  logic [5:0]  pdiv;

  always_comb begin
    mul  = 9'(in_data.pll_control[19:12]) + 9'd8;
    pdiv = in_data.pll_control[9:4];
    stage_nxt               = '0;
    stage_nxt.valid         = in_valid;
    stage_nxt.rem           = '0;
    stage_nxt.nq            = NUM_W'(REF_HZ) * NUM_W'(mul);
    stage_nxt.dsr           = DSR_W'(pdiv) + DSR_W'(2);
    stage_nxt.ctx.slow_mode = in_data.slow_control[4];
    stage_nxt.ctx.slow_hz   = slow_clock(in_data.slow_control[2:0]);
    stage_nxt.ctx.sdiv      = in_data.pll_control[1:0];
    stage_nxt.ctx.halve     = in_data.divider_control[1];
    stage_nxt.ctx.w1_keep   = in_data.lcd_word1_in[7:1];
    stage_nxt.ctx.w3_keep   = in_data.lcd_word3_in[18:8];
    stage_nxt.ctx.w4_keep   = in_data.lcd_word4_in[31:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= stage_nxt;
    end
  end

  always_comb begin
    div_out       = data_r;
    div_out.valid = valid_r;
  end

endmodule

// ----- hdl/lctc_div.sv -----
// Pipelined restoring divider: several quotient bits per stage, context carried along.
module lctc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  lctc_pkg::lctc_div_t div_in,
  output lctc_pkg::lctc_div_t div_out
);
  import lctc_pkg::*;

  lctc_div_t stg_in  [DIV_STAGES];
  lctc_div_t stg_nxt [DIV_STAGES];
  lctc_div_t stg_r   [DIV_STAGES];
  logic      vld_r   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign stg_in[s] = div_in;
    end else begin : g_rest
      always_comb begin
        stg_in[s]       = stg_r[s-1];
        stg_in[s].valid = vld_r[s-1];
      end
    end

    always_comb begin
      logic [DSR_W:0]   trial;
      logic [DSR_W-1:0] rem;
      logic [NUM_W-1:0] nq;
      rem = stg_in[s].rem;
      nq  = stg_in[s].nq;
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem, nq[NUM_W-1]};
        nq    = {nq[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, stg_in[s].dsr}) begin
          rem   = DSR_W'(trial - {1'b0, stg_in[s].dsr});
          nq[0] = 1'b1;
        end else begin
          rem = trial[DSR_W-1:0];
        end
      end
      stg_nxt[s]     = stg_in[s];
      stg_nxt[s].rem = rem;
      stg_nxt[s].nq  = nq;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= stg_in[s].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  always_comb begin
    div_out       = stg_r[DIV_STAGES-1];
    div_out.valid = vld_r[DIV_STAGES-1];
  end

endmodule

// ----- hdl/lctc_back.sv -----
// Back end: bus clock select, pixel divider by reciprocal, output word assembly.
module lctc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  lctc_pkg::lctc_div_t  div_in,
  output logic                 out_valid,
  output lctc_pkg::lctc_out_t  out_data
);
  import lctc_pkg::*;

  // stage 1: bus clock
  logic            v1_r;
  logic [HZ_W-1:0] f1_r;
  lctc_ctx_t       ctx1_r;
  logic [HZ_W-1:0] core;
  logic [HZ_W-1:0] f1_nxt;

  // stage 2: reciprocal product and speed flags
  logic              v2_r;
  logic [HZ_W-1:0]   f2_r;
  logic [PROD_W-1:0] prod_r;
  logic              fast_r;
  logic              faster_r;
  lctc_ctx_t         ctx2_r;

  // stage 3: output register
  logic        vout_r;
  lctc_out_t   out_r;
  lctc_out_t   out_nxt;
  logic [Q500_W-1:0] q500;
  logic [Q500_W-1:0] pix_div;
  logic [Q500_W-3:0] blank;
  logic [9:0]        div_sat;
  logic [7:0]        blank_sat;

  always_comb begin
    if (div_in.ctx.slow_mode) begin
      core = HZ_W'(div_in.ctx.slow_hz);
    end else begin
      core = HZ_W'(div_in.nq >> div_in.ctx.sdiv);
    end
    f1_nxt = div_in.ctx.halve ? (core >> 1) : core;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      vout_r <= 1'b0;
    end else if (en) begin
      v1_r   <= div_in.valid;
      v2_r   <= v1_r;
      vout_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r     <= f1_nxt;
      ctx1_r   <= div_in.ctx;
      f2_r     <= f1_r;
      prod_r   <= PROD_W'(f1_r) * PROD_W'(PIX_RECIP);
      fast_r   <= f1_r > HZ_W'(FAST_HZ);
      faster_r <= f1_r > HZ_W'(FASTER_HZ);
      ctx2_r   <= ctx1_r;
      out_r    <= out_nxt;
    end
  end

  always_comb begin
    q500      = prod_r[PROD_W-1:RECIP_SHIFT];
    pix_div   = (q500 + Q500_W'(1)) >> 1;
    blank     = q500[Q500_W-1:2];
    div_sat   = (pix_div > Q500_W'(DIV_MAX)) ? 10'(DIV_MAX) : pix_div[9:0];
    blank_sat = (blank > (Q500_W-2)'(BLANK_MAX)) ? 8'(BLANK_MAX) : blank[7:0];

    out_nxt.lcd_word1_out = {14'd0, div_sat, ctx2_r.w1_keep, 1'b1};
    out_nxt.lcd_word3_out = {11'd0, faster_r, fast_r, ctx2_r.w3_keep, blank_sat};
    out_nxt.lcd_word4_out = {ctx2_r.w4_keep, 6'd0, faster_r, fast_r};
    out_nxt.bus_clock_hz  = f2_r;
  end

  assign out_valid = vout_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/lcd_clock_timing_calc_core.sv -----
// Top level of the LCD clock timing calculator: front, divider and back pipeline.
// Throughput: one item per cycle while the output is not stalled; set by the
// single-rate pipeline, whose four divider stages each resolve eight quotient
// bits of the PLL division.
// Reset: synchronous, active-low rst_n clears every stage valid bit; payload
// registers are not reset.
module lcd_clock_timing_calc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lctc_pkg::lctc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lctc_pkg::lctc_out_t out_data
);
  import lctc_pkg::*;

  // Advance the whole pipe whenever the output register is empty or being
  // drained; otherwise hold every stage, so a stall drops nothing.
  logic      advance;
  lctc_div_t front_to_div;
  lctc_div_t div_to_back;

  assign advance  = out_ready || !out_valid;
  assign in_ready = advance;

  // Decode fields, form 12 MHz * (mdiv+8) and the divisor pdiv+2.
  lctc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (in_valid),
    .in_data  (in_data),
    .div_out  (front_to_div)
  );

  // Divide the PLL product by pdiv+2.
  lctc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .div_in  (front_to_div),
    .div_out (div_to_back)
  );

  // Pick slow or PLL clock, apply sdiv and halving, then build the words.
  lctc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .div_in    (div_to_back),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- sim/lctc_result_checker.sv -----
// Result checker for the LCD clock timing calculator: predicts every transfer and compares.
module lctc_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lctc_pkg::lctc_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lctc_pkg::lctc_out_t out_data,
  output int                  mismatches,
  output int                  outstanding
);
  import lctc_pkg::*;

  localparam longint unsigned PIXEL_HZ = 500000;
  localparam longint unsigned BLANK_HZ = 2000000;

  lctc_out_t expected_words[$];
  int        errors  = 0;
  int        waiting = 0;

  assign mismatches  = errors;
  assign outstanding = waiting;

  // bus clock from the clock words, then the three rewritten LCD words
  function automatic lctc_out_t timing_words(input lctc_in_t d);
    logic [63:0] bus_hz;
    logic [63:0] pix_div;
    logic [63:0] blank;
    lctc_out_t   r;
    bus_hz = 64'(REF_HZ);
    if (d.slow_control[4]) begin
      if (d.slow_control[2:0] != 3'd0)
        bus_hz = bus_hz / {60'd0, d.slow_control[2:0], 1'b0};
    end else begin
      bus_hz = bus_hz * (64'(d.pll_control[19:12]) + 64'd8);
      bus_hz = bus_hz / (64'(d.pll_control[9:4]) + 64'd2);
      bus_hz = bus_hz >> d.pll_control[1:0];
    end
    if (d.divider_control[1])
      bus_hz = bus_hz / 64'd2;
    pix_div = ((bus_hz / PIXEL_HZ) + 64'd1) >> 1;
    if (pix_div > DIV_MAX)
      pix_div = 64'(DIV_MAX);
    blank = bus_hz / BLANK_HZ;
    if (blank > BLANK_MAX)
      blank = 64'(BLANK_MAX);
    r.lcd_word1_out = {14'd0, pix_div[9:0], d.lcd_word1_in[7:1], 1'b1};
    r.lcd_word3_out = {11'd0, bus_hz > FASTER_HZ, bus_hz > FAST_HZ,
                       d.lcd_word3_in[18:8], blank[7:0]};
    r.lcd_word4_out = {d.lcd_word4_in[31:8], 6'd0, bus_hz > FASTER_HZ, bus_hz > FAST_HZ};
    r.bus_clock_hz  = bus_hz[30:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    lctc_out_t want;
    if (rst_n) begin
      // pop before push so a stray result never meets a same-edge expectation
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got %h", $time, out_data);
        end else begin
          want = expected_words.pop_front();
          check_field("lcd_word1_out", want.lcd_word1_out, out_data.lcd_word1_out);
          check_field("lcd_word3_out", want.lcd_word3_out, out_data.lcd_word3_out);
          check_field("lcd_word4_out", want.lcd_word4_out, out_data.lcd_word4_out);
          check_field("bus_clock_hz", {1'b0, want.bus_clock_hz},
                      {1'b0, out_data.bus_clock_hz});
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(timing_words(in_data));
    end
    waiting = expected_words.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the LCD clock timing calculator: stimulus, reset and verdict.
module tb_top;
  import lctc_pkg::*;

  localparam int ITEM_COUNT   = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  // pipeline is 8 deep; give it a little more to flush out stray results
  localparam int DRAIN_CYCLES = 24;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  lctc_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lctc_out_t out_data;

  int mismatches;
  int outstanding;
  int cycle_count;
  // no idling on either side while set
  bit steady = 1'b0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  lcd_clock_timing_calc_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lctc_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Stall the result side about 16 percent of the time, except in the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  function automatic lctc_in_t make_item(input logic [19:0] pll, input logic [7:0] slow,
                                         input logic [1:0] divc, input logic [31:0] w1,
                                         input logic [31:0] w3, input logic [31:0] w4);
    lctc_in_t d;
    d.pll_control     = pll;
    d.slow_control    = slow;
    d.divider_control = divc;
    d.lcd_word1_in    = w1;
    d.lcd_word3_in    = w3;
    d.lcd_word4_in    = w4;
    return d;
  endfunction

  // Mostly PLL mode, where the clock spans its whole range; slow mode has
  // only eight divider settings, so give it a quarter of the items.
  function automatic lctc_in_t random_item();
    lctc_in_t d;
    d.pll_control     = 20'($urandom);
    d.slow_control    = 8'($urandom);
    d.slow_control[4] = ($urandom_range(0, 3) == 0);
    d.divider_control = 2'($urandom_range(0, 3));
    d.lcd_word1_in    = $urandom;
    d.lcd_word3_in    = $urandom;
    d.lcd_word4_in    = $urandom;
    return d;
  endfunction

  // Present one item from a falling edge and hold it until the transfer.
  // Valid stays high on return so back-to-back items never drop it.
  task automatic push_item(input lctc_in_t d);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off the sender until every expected result is back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
  endtask

  // Watchdog: end the run if the pipeline wedges or a result never comes.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    // Hold reset from the start, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes and the clock thresholds.
    // all zero: 12 MHz * 8 / 2 = 48 MHz
    push_item(make_item(20'h00000, 8'h00, 2'd0, 32'h0, 32'h0, 32'h0));
    // every PLL bit set, halved, all word bits set
    push_item(make_item(20'hFFFFF, 8'h00, 2'd3, '1, '1, '1));
    // fastest clock: divider and line blank both saturate
    push_item(make_item(20'hFF000, 8'h00, 2'd0, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
    // halved fastest clock: only line blank saturates
    push_item(make_item(20'hFF000, 8'h00, 2'd2, 32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    // slowest clock: everything rounds down to zero
    push_item(make_item(20'h003F3, 8'h00, 2'd2, 32'h0, '1, 32'h0));
    // only the unused PLL bits set
    push_item(make_item(20'h00C0C, 8'h00, 2'd1, '1, 32'h0, '1));
    // exactly 37.5 MHz: no wait-delay bits
    push_item(make_item(20'h11060, 8'h00, 2'd0, 32'h0, 32'h0, 32'h0));
    // 38 MHz: just over the first threshold
    push_item(make_item(20'h44160, 8'h00, 2'd0, 32'h0, 32'h0, 32'h0));
    // exactly 60 MHz, then 66 MHz
    push_item(make_item(20'h02000, 8'h00, 2'd0, 32'h0, 32'h0, 32'h0));
    push_item(make_item(20'h03000, 8'h00, 2'd0, 32'h0, 32'h0, 32'h0));
    // 120 MHz halved to exactly 60 MHz
    push_item(make_item(20'h0C000, 8'h00, 2'd2, '1, '1, '1));
    // 150 MHz shifted down to 37.5 MHz
    push_item(make_item(20'h11002, 8'h00, 2'd0, '1, '1, '1));
    // slow mode with a zero divider keeps the 12 MHz reference
    push_item(make_item(20'hFFFFF, 8'h10, 2'd0, 32'h0, 32'h0, 32'h0));
    // slow mode, largest divider, then with every unused slow bit set
    push_item(make_item(20'h00000, 8'h17, 2'd0, 32'h0, 32'h0, 32'h0));
    push_item(make_item(20'hFF000, 8'hFF, 2'd3, '1, '1, '1));
    // slow bit clear but every other slow bit set: PLL path
    push_item(make_item(20'h00000, 8'hEF, 2'd0, 32'h0, 32'h0, 32'h0));
    // slow divider of one, halved
    push_item(make_item(20'h00000, 8'h11, 2'd2, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F));

    // Let the pipeline empty before the random part.
    hold_until_drained();

    for (int i = 0; i < ITEM_COUNT; i++) begin
      steady = (i >= 300 && i < 550);
      if (i == 750)
        hold_until_drained();
      push_item(random_item());
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
